// File: rtl/npzw_pkg.sv
`default_nettype none
package npzw_pkg;

    // digit width of the partial-product multipliers
    localparam int MUL_CHUNK = 16;

    localparam int                     W_MASS_BITS   = 20;
    localparam logic [W_MASS_BITS-1:0] W_MASS_RESET  = 20'd80399;

    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_INDEX_BITS = CFG_ADDR_BITS - 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_W_MASS = 1'b0;

    typedef struct packed {
        logic no_real;
        logic degen;
        logic neg_sign;
    } t_item_flags;

endpackage
`default_nettype wire

// File: rtl/npzw_delay.sv
`default_nettype none
module npzw_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_q
);

    logic [W-1:0] r_sh [N];

    always_ff @(posedge i_clk) begin
        r_sh[0] <= i_d;
    end

    for (genvar k = 1; k < N; k++) begin : g_tap
        always_ff @(posedge i_clk) begin
            r_sh[k] <= r_sh[k-1];
        end
    end

    assign o_q = r_sh[N-1];

endmodule
`default_nettype wire

// File: rtl/npzw_mul.sv
`default_nettype none
module npzw_mul
    import npzw_pkg::*;
#(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  wire logic                 i_clk,
    input  wire logic signed [WA-1:0] i_a,
    input  wire logic signed [WB-1:0] i_b,
    output logic signed [WA+WB-1:0]   o_p
);

    localparam int WP = WA + WB;
    localparam int NC = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int BE = NC * MUL_CHUNK;

    logic signed [WA-1:0] r_a   [NC];
    logic        [BE-1:0] r_b   [NC];
    logic signed [WP-1:0] r_acc [NC];
    logic        [BE-1:0] b_ext;

    assign b_ext = BE'(i_b);

    // one digit of b per stage; the top digit carries the sign
    for (genvar j = 0; j < NC; j++) begin : g_stage
        logic signed [WA-1:0]          a_in;
        logic        [BE-1:0]          b_in;
        logic signed [WP-1:0]          acc_in;
        logic signed [MUL_CHUNK:0]     dig;
        logic signed [WA+MUL_CHUNK:0]  pp;
        logic signed [WP-1:0]          n_acc;

        if (j == 0) begin : g_first
            assign a_in   = i_a;
            assign b_in   = b_ext;
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = r_a[j-1];
            assign b_in   = r_b[j-1];
            assign acc_in = r_acc[j-1];
        end

        if (j == NC-1) begin : g_top
            assign dig = $signed({b_in[MUL_CHUNK-1], b_in[MUL_CHUNK-1:0]});
        end else begin : g_low
            assign dig = $signed({1'b0, b_in[MUL_CHUNK-1:0]});
        end

        assign pp    = a_in * dig;
        assign n_acc = acc_in + (WP'(pp) <<< (MUL_CHUNK * j));

        always_ff @(posedge i_clk) begin
            r_acc[j] <= n_acc;
        end

        if (j < NC-1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                r_a[j] <= a_in;
                r_b[j] <= b_in >> MUL_CHUNK;
            end
        end
    end

    assign o_p = r_acc[NC-1];

endmodule
`default_nettype wire

// File: rtl/npzw_sqrt.sv
`default_nettype none
module npzw_sqrt #(
    parameter int DW = 16
) (
    input  wire logic            i_clk,
    input  wire logic [DW-1:0]   i_d,
    output logic      [DW/2-1:0] o_s
);

    localparam int SW = DW / 2;

    logic [DW-1:0] r_rem  [SW];
    logic [SW-1:0] r_root [SW];

    // one root bit per stage, msb first; rem = d - root^2
    for (genvar i = 0; i < SW; i++) begin : g_stage
        localparam int BI = SW - 1 - i;
        logic [DW-1:0] rem_in;
        logic [SW-1:0] root_in;
        logic [DW-1:0] trial;
        logic          ge;

        if (i == 0) begin : g_first
            assign rem_in  = i_d;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[i-1];
            assign root_in = r_root[i-1];
        end

        assign trial = (DW'(root_in) << (BI + 1)) | (DW'(1'b1) << (2 * BI));
        assign ge    = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            r_root[i] <= ge ? (root_in | (SW'(1'b1) << BI)) : root_in;
        end

        if (i < SW-1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[i] <= ge ? (rem_in - trial) : rem_in;
            end
        end
    end

    assign o_s = r_root[SW-1];

endmodule
`default_nettype wire

// File: rtl/npzw_div.sv
`default_nettype none
module npzw_div #(
    parameter int NW = 16,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [NW-1:0] o_q
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [DW-1:0] r_den [NW];
    logic [NW-1:0] r_q   [NW];

    // restoring division, one quotient bit per stage
    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NW-1:0] num_in;
        logic [DW-1:0] den_in;
        logic [NW-1:0] q_in;
        logic [DW:0]   t;
        logic [DW:0]   diff;
        logic          ge;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[i-1];
            assign num_in = r_num[i-1];
            assign den_in = r_den[i-1];
            assign q_in   = r_q[i-1];
        end

        assign t    = {rem_in, num_in[NW-1]};
        assign diff = t - {1'b0, den_in};
        assign ge   = t >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            r_q[i] <= {q_in[NW-2:0], ge};
        end

        if (i < NW-1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                r_rem[i] <= ge ? diff[DW-1:0] : t[DW-1:0];
                r_num[i] <= num_in << 1;
                r_den[i] <= den_in;
            end
        end
    end

    assign o_q = r_q[NW-1];

endmodule
`default_nettype wire

// File: rtl/neutrino_pz_w_mass_solver_top.sv
// Pipeline: each item runs through multiplier banks, a bit-serial sqrt and a divider to o_done.
//   MB = MOMENTUM_BITS; each multiplier bank has ceil(width / 16) digit stages
//   (widths MB, 2*MB + 4 and 4*MB + 9); the bit-serial sqrt and divide pipelines are deepest.
// Throughput: one item per cycle, busy is never raised.
// o_done pulses for one cycle per item; the receiver cannot stall.
// Reset (synchronous, active low) clears the valid pipeline and sets r_w_mass to 80399.
`default_nettype none
module neutrino_pz_w_mass_solver_top
    import npzw_pkg::*;
#(
    parameter int MOMENTUM_BITS = 36
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic        [MOMENTUM_BITS-2:0] i_lepton_energy,
    input  wire logic signed [MOMENTUM_BITS-1:0] i_lepton_px,
    input  wire logic signed [MOMENTUM_BITS-1:0] i_lepton_py,
    input  wire logic signed [MOMENTUM_BITS-1:0] i_lepton_pz,
    input  wire logic signed [MOMENTUM_BITS-1:0] i_missing_px,
    input  wire logic signed [MOMENTUM_BITS-1:0] i_missing_py,
    output logic                                 o_done,
    output logic signed      [MOMENTUM_BITS-1:0] o_neutrino_pz,
    output logic                                 o_no_real_root,
    output logic                                 o_degenerate,
    output logic                                 o_saturated,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic        [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic        [CFG_DATA_BITS-1:0] pwdata,
    output logic             [CFG_DATA_BITS-1:0] prdata,
    output logic                                 pready
);

    localparam int MB   = MOMENTUM_BITS;
    localparam int KW   = 2 * MB + 4;
    localparam int AW   = 2 * MB;
    localparam int QW   = 2 * KW + 1;
    localparam int KPW  = MB + KW;
    localparam int DPW  = QW + AW;
    localparam int DW   = DPW - 1;
    localparam int SW   = DW / 2;
    localparam int NW   = KPW + 2;
    localparam int L1   = (MB + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int L3   = (KW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int L5   = (QW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int L6   = SW;
    localparam int L8   = NW;
    localparam int TOT  = L1 + 3 + L3 + 1 + L5 + L6 + 3 + L8 + 2;
    localparam int P5W  = KPW + AW + 3;

    // ---------------- configuration ----------------
    logic [W_MASS_BITS-1:0] r_w_mass;
    logic                   cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = paddr[CFG_ADDR_BITS-1:2] == REG_W_MASS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_mass <= W_MASS_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_w_mass <= pwdata[W_MASS_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_sel) begin
            prdata = CFG_DATA_BITS'(r_w_mass);
        end
    end

    // ---------------- valid line ----------------
    logic [TOT-1:0] r_vld;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOT-2:0], start && !busy};
        end
    end

    // ---------------- squares and cross products ----------------
    logic signed [MB-1:0]   e_s;
    logic signed [MB-1:0]   mw_s;
    logic signed [2*MB-1:0] e2, px2, py2, pz2, mx2, my2, pxmx, pymy, mw2;
    logic signed [MB-1:0]   pz_d1;

    assign e_s  = $signed({1'b0, i_lepton_energy});
    assign mw_s = $signed(MB'(r_w_mass));

    npzw_mul #(.WA(MB), .WB(MB)) u_mul_e2 (.i_clk, .i_a(e_s), .i_b(e_s), .o_p(e2));
    npzw_mul #(.WA(MB), .WB(MB)) u_mul_px2 (
        .i_clk, .i_a(i_lepton_px), .i_b(i_lepton_px), .o_p(px2));
    npzw_mul #(.WA(MB), .WB(MB)) u_mul_py2 (
        .i_clk, .i_a(i_lepton_py), .i_b(i_lepton_py), .o_p(py2));
    npzw_mul #(.WA(MB), .WB(MB)) u_mul_pz2 (
        .i_clk, .i_a(i_lepton_pz), .i_b(i_lepton_pz), .o_p(pz2));
    npzw_mul #(.WA(MB), .WB(MB)) u_mul_mx2 (
        .i_clk, .i_a(i_missing_px), .i_b(i_missing_px), .o_p(mx2));
    npzw_mul #(.WA(MB), .WB(MB)) u_mul_my2 (
        .i_clk, .i_a(i_missing_py), .i_b(i_missing_py), .o_p(my2));
    npzw_mul #(.WA(MB), .WB(MB)) u_mul_pxmx (
        .i_clk, .i_a(i_lepton_px), .i_b(i_missing_px), .o_p(pxmx));
    npzw_mul #(.WA(MB), .WB(MB)) u_mul_pymy (
        .i_clk, .i_a(i_lepton_py), .i_b(i_missing_py), .o_p(pymy));
    npzw_mul #(.WA(MB), .WB(MB)) u_mul_mw2 (.i_clk, .i_a(mw_s), .i_b(mw_s), .o_p(mw2));

    npzw_delay #(.W(MB), .N(L1)) u_dly_pz (.i_clk, .i_d(i_lepton_pz), .o_q(pz_d1));

    // ---------------- sums: p^2, k partial, a, mt^2 ----------------
    logic signed [KW-1:0] r_p2_a, r_kk_a, r_mt2_a, r_kk_b, r_mt2_b, r_m2_b, r_k_c, r_mt2_c;
    logic signed [AW-1:0] r_a_a, r_e2_a, r_a_b, r_e2_b, r_a_c, r_e2_c;
    logic signed [MB-1:0] r_pz_a, r_pz_b, r_pz_c;
    logic signed [KW-1:0] m2_raw;

    assign m2_raw = KW'(r_e2_a) - r_p2_a;

    always_ff @(posedge i_clk) begin
        r_p2_a  <= KW'(px2) + KW'(py2) + KW'(pz2);
        r_kk_a  <= ((KW'(pxmx) + KW'(pymy)) <<< 1) + KW'(mw2);
        r_mt2_a <= KW'(mx2) + KW'(my2);
        r_a_a   <= e2 - pz2;
        r_e2_a  <= e2;
        r_pz_a  <= pz_d1;

        // lepton mass squared clamped at zero
        r_m2_b  <= m2_raw[KW-1] ? '0 : m2_raw;
        r_kk_b  <= r_kk_a;
        r_mt2_b <= r_mt2_a;
        r_a_b   <= r_a_a;
        r_e2_b  <= r_e2_a;
        r_pz_b  <= r_pz_a;

        r_k_c   <= r_kk_b - r_m2_b;
        r_mt2_c <= r_mt2_b;
        r_a_c   <= r_a_b;
        r_e2_c  <= r_e2_b;
        r_pz_c  <= r_pz_b;
    end

    // ---------------- K*pz, K^2, a*mt^2 ----------------
    logic signed [KPW-1:0]   kp;
    logic signed [2*KW-1:0]  kk;
    logic signed [AW+KW-1:0] amt;
    logic signed [AW-1:0]    e2_d3, a_d3;

    npzw_mul #(.WA(MB), .WB(KW)) u_mul_kp (.i_clk, .i_a(r_pz_c), .i_b(r_k_c), .o_p(kp));
    npzw_mul #(.WA(KW), .WB(KW)) u_mul_kk (.i_clk, .i_a(r_k_c), .i_b(r_k_c), .o_p(kk));
    npzw_mul #(.WA(AW), .WB(KW)) u_mul_amt (.i_clk, .i_a(r_a_c), .i_b(r_mt2_c), .o_p(amt));

    npzw_delay #(.W(2*AW), .N(L3)) u_dly_ea (
        .i_clk, .i_d({r_e2_c, r_a_c}), .o_q({e2_d3, a_d3}));

    // ---------------- discriminant ----------------
    logic signed [QW-1:0]  q_val;
    logic signed [QW-1:0]  r_q_pos;
    logic signed [AW-1:0]  r_e2_4;
    logic signed [KPW-1:0] r_kp_4;
    logic        [AW-1:0]  r_absa_4;
    logic                  r_asign_4, r_noreal_4, r_degen_4;

    assign q_val = QW'(kk) - (QW'(amt) <<< 2);

    always_ff @(posedge i_clk) begin
        r_q_pos    <= q_val[QW-1] ? '0 : q_val;
        r_noreal_4 <= q_val[QW-1] && (e2_d3 != '0);
        r_degen_4  <= a_d3 == '0;
        r_absa_4   <= a_d3[AW-1] ? AW'(-a_d3) : a_d3;
        r_asign_4  <= a_d3[AW-1];
        r_e2_4     <= e2_d3;
        r_kp_4     <= kp;
    end

    // ---------------- E^2*Q and its square root ----------------
    logic signed [DPW-1:0] d_val;
    logic        [SW-1:0]  s_val;
    logic signed [KPW-1:0] kp_d6;
    logic        [AW-1:0]  absa_d6;
    logic                  asign_d6, noreal_d6, degen_d6;

    // the narrow operand goes to the digit array, the wide one is split into digits
    npzw_mul #(.WA(AW), .WB(QW)) u_mul_d (.i_clk, .i_a(r_e2_4), .i_b(r_q_pos), .o_p(d_val));

    npzw_sqrt #(.DW(DW)) u_sqrt (.i_clk, .i_d(d_val[DW-1:0]), .o_s(s_val));

    npzw_delay #(.W(P5W), .N(L5 + L6)) u_dly_root (
        .i_clk,
        .i_d({r_kp_4, r_absa_4, r_asign_4, r_noreal_4, r_degen_4}),
        .o_q({kp_d6, absa_d6, asign_d6, noreal_d6, degen_d6})
    );

    // ---------------- numerator and divisor ----------------
    logic signed [NW-1:0] kp_ext, s_ext, n_num;
    logic                 kp_pos;
    logic signed [NW-1:0] r_n_7a;
    logic        [NW-1:0] r_nabs_7b, r_num_7c;
    logic        [AW-1:0] r_absa_7a, r_absa_7b, r_den_7c;
    logic                 r_asign_7a, r_noreal_7a, r_degen_7a;
    logic                 r_asign_7b, r_nsign_7b, r_noreal_7b, r_degen_7b;
    t_item_flags          r_flags_7c, flags_d8;

    assign kp_ext = NW'(kp_d6);
    assign s_ext  = $signed(NW'(s_val));
    assign kp_pos = !kp_d6[KPW-1] && (kp_d6 != '0);

    // smaller-magnitude root; + root on a tie
    always_comb begin
        if (noreal_d6) begin
            n_num = kp_ext;
        end else if (kp_pos) begin
            n_num = kp_ext - s_ext;
        end else begin
            n_num = kp_ext + s_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n_7a      <= n_num;
        r_absa_7a   <= absa_d6;
        r_asign_7a  <= asign_d6;
        r_noreal_7a <= noreal_d6;
        r_degen_7a  <= degen_d6;

        r_nabs_7b   <= r_n_7a[NW-1] ? NW'(-r_n_7a) : r_n_7a;
        r_nsign_7b  <= r_n_7a[NW-1];
        r_absa_7b   <= r_absa_7a;
        r_asign_7b  <= r_asign_7a;
        r_noreal_7b <= r_noreal_7a;
        r_degen_7b  <= r_degen_7a;

        // round half away: (|n| + |a|) / (2|a|)
        r_num_7c            <= r_nabs_7b + NW'(r_absa_7b);
        r_den_7c            <= {r_absa_7b[AW-2:0], 1'b0};
        r_flags_7c.no_real  <= r_noreal_7b;
        r_flags_7c.degen    <= r_degen_7b;
        r_flags_7c.neg_sign <= r_nsign_7b ^ r_asign_7b;
    end

    // ---------------- division ----------------
    logic [NW-1:0] quo;

    npzw_div #(.NW(NW), .DW(AW)) u_div (
        .i_clk, .i_num(r_num_7c), .i_den(r_den_7c), .o_q(quo));

    npzw_delay #(.W($bits(t_item_flags)), .N(L8)) u_dly_flags (
        .i_clk, .i_d(r_flags_7c), .o_q(flags_d8));

    // ---------------- saturation and sign ----------------
    logic          negres, sat;
    logic [MB-1:0] lim;
    logic [MB-1:0] r_mag;
    logic          r_negres, r_sat_9, r_noreal_9, r_degen_9;
    logic [MB-1:0] r_pz_out;
    logic          r_noreal_out, r_degen_out, r_sat_out;

    assign negres = flags_d8.neg_sign && (quo != '0);
    assign lim    = negres ? {1'b1, {(MB-1){1'b0}}} : {1'b0, {(MB-1){1'b1}}};
    assign sat    = quo > NW'(lim);

    always_ff @(posedge i_clk) begin
        r_mag      <= sat ? lim : quo[MB-1:0];
        r_negres   <= negres;
        r_sat_9    <= sat;
        r_noreal_9 <= flags_d8.no_real;
        r_degen_9  <= flags_d8.degen;

        if (r_degen_9) begin
            r_pz_out <= '0;
        end else if (r_negres) begin
            r_pz_out <= '0 - r_mag;
        end else begin
            r_pz_out <= r_mag;
        end
        r_noreal_out <= r_noreal_9 && !r_degen_9;
        r_sat_out    <= r_sat_9 && !r_degen_9;
        r_degen_out  <= r_degen_9;
    end

    assign o_done         = r_vld[TOT-1];
    assign o_neutrino_pz  = $signed(r_pz_out);
    assign o_no_real_root = r_noreal_out;
    assign o_degenerate   = r_degen_out;
    assign o_saturated    = r_sat_out;

    // ---------------- checks ----------------
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated) |->
            (r_pz_out == {1'b0, {(MB-1){1'b1}}} || r_pz_out == {1'b1, {(MB-1){1'b0}}}))
        else $error("saturated beat not at range limit");

    a_degen_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |->
            (r_pz_out == '0 && !o_no_real_root && !o_saturated))
        else $error("degenerate beat carries result or flags");

    a_vld_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[TOT-1] |-> $past(r_vld[0], TOT-1))
        else $error("result beat without matching accepted item");

endmodule
`default_nettype wire

// File: tb/sv/tb_neutrino_pz_w_mass_solver_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_neutrino_pz_w_mass_solver_top;
    import npzw_pkg::*;

    localparam int MB = 36;
    localparam int SETTLE_CYCLES = 260;  // longer than the pipeline depth

    typedef logic signed [383:0] wide_t;

    typedef struct {
        logic signed [MB-1:0] pz;
        logic                 no_real;
        logic                 degen;
        logic                 sat;
    } pz_result_t;

    class pz_scoreboard;
        pz_result_t pending_q[$];
        int         n_err;
        int         n_seen;
        int         n_noreal;
        int         n_degen;
        int         n_sat;

        static function wide_t isqrt(wide_t v);
            logic [383:0] r;
            logic [383:0] t;
            r = '0;
            for (int i = 191; i >= 0; i--) begin
                t = r | (384'd1 << i);
                if (t * t <= v) r = t;
            end
            return wide_t'(r);
        endfunction

        // W-mass constraint solve for one beat
        function void note_input(logic [MB-2:0] e_in, logic signed [MB-1:0] lx,
                                 logic signed [MB-1:0] ly, logic signed [MB-1:0] lz,
                                 logic signed [MB-1:0] nx, logic signed [MB-1:0] ny,
                                 logic [W_MASS_BITS-1:0] mass);
            wide_t e, px, py, pz, mx, my, mw, e2, m2, mt2, k, a, kp, q, d, s, n;
            wide_t an, quo, lim;
            logic       neg;
            pz_result_t r;
            e = e_in; px = lx; py = ly; pz = lz; mx = nx; my = ny; mw = mass;
            r.no_real = 0; r.degen = 0; r.sat = 0; r.pz = '0;
            e2  = e * e;
            m2  = e2 - px * px - py * py - pz * pz;
            if (m2 < 0) m2 = 0;
            mt2 = mx * mx + my * my;
            k   = 2 * (px * mx + py * my) + mw * mw - m2;
            a   = e2 - pz * pz;
            if (a == 0) begin
                r.degen = 1;
            end else begin
                kp = k * pz;
                q  = k * k - 4 * a * mt2;
                if (q < 0 && e != 0) begin
                    r.no_real = 1;
                    n = kp;
                end else begin
                    d = e2 * q;
                    if (d < 0) d = 0;
                    s = isqrt(d);
                    n = (kp > 0) ? kp - s : kp + s;
                end
                an  = (a < 0) ? -a : a;
                quo = ((n < 0) ? -n : n) + an;
                quo = quo / (2 * an);
                neg = ((n < 0) != (a < 0)) && quo != 0;
                lim = (wide_t'(1) <<< (MB - 1)) - (neg ? 0 : 1);
                if (quo > lim) begin
                    quo = lim;
                    r.sat = 1;
                end
                if (neg) quo = -quo;
                r.pz = quo[MB-1:0];
            end
            pending_q.insert(pending_q.size(), r);
        endfunction

        function void check_result(pz_result_t got);
            pz_result_t x;
            n_seen++;
            if (pending_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result beat pz=%0d", got.pz);
                return;
            end
            x = pending_q.pop_front();
            n_noreal += x.no_real;
            n_degen  += x.degen;
            n_sat    += x.sat;
            if (x.pz !== got.pz || x.no_real !== got.no_real || x.degen !== got.degen
                    || x.sat !== got.sat) begin
                n_err++;
                if (n_err <= 10)
                    $display({"mismatch: exp pz=%0d nr=%b dg=%b st=%b,",
                              " got pz=%0d nr=%b dg=%b st=%b"},
                             x.pz, x.no_real, x.degen, x.sat,
                             got.pz, got.no_real, got.degen, got.sat);
            end
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  start = 0;
    logic                  busy;
    logic        [MB-2:0]  i_lepton_energy = '0;
    logic signed [MB-1:0]  i_lepton_px = '0, i_lepton_py = '0, i_lepton_pz = '0;
    logic signed [MB-1:0]  i_missing_px = '0, i_missing_py = '0;
    logic                  o_done;
    logic signed [MB-1:0]  o_neutrino_pz;
    logic                  o_no_real_root, o_degenerate, o_saturated;
    logic                  psel = 0, penable = 0, pwrite = 0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                  pready;

    neutrino_pz_w_mass_solver_top #(.MOMENTUM_BITS(MB)) DUT (.*);

    always #5 i_clk = ~i_clk;

    pz_scoreboard           sb = new();
    logic [W_MASS_BITS-1:0] w_mass = W_MASS_RESET;
    int                     idle_pct = 0;
    int                     n_items = 0;

    // next beat's fields
    logic        [MB-2:0]   n_e;
    logic signed [MB-1:0]   n_px, n_py, n_pz, n_mx, n_my;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result('{o_neutrino_pz, o_no_real_root, o_degenerate, o_saturated});
    end

    task automatic send_beat();
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_lepton_energy <= n_e;
        i_lepton_px     <= n_px;
        i_lepton_py     <= n_py;
        i_lepton_pz     <= n_pz;
        i_missing_px    <= n_mx;
        i_missing_py    <= n_my;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_input(n_e, n_px, n_py, n_pz, n_mx, n_my, w_mass);
        n_items++;
    endtask

    task automatic go_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mass(logic [W_MASS_BITS-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'(REG_W_MASS) << 2;
        pwdata  <= CFG_DATA_BITS'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        w_mass = v;
        @(posedge i_clk);
    endtask

    function automatic logic signed [MB-1:0] rand_comp(int bits);
        logic signed [MB-1:0] v;
        v = MB'($urandom_range(0, (1 << bits) - 1));
        return $urandom_range(1) ? -v : v;
    endfunction

    task automatic direct(logic [MB-2:0] e, logic signed [MB-1:0] lx, logic signed [MB-1:0] ly,
                          logic signed [MB-1:0] lz, logic signed [MB-1:0] nx,
                          logic signed [MB-1:0] ny);
        n_e = e; n_px = lx; n_py = ly; n_pz = lz; n_mx = nx; n_my = ny;
        send_beat();
    endtask

    task automatic rand_beat();
        wide_t p2;
        int    bits;
        int    mode;
        mode = $urandom_range(9);
        bits = $urandom_range(8, 30);
        n_px = rand_comp(bits);
        n_py = rand_comp(bits);
        n_pz = rand_comp(bits);
        n_mx = rand_comp($urandom_range(4, 30));
        n_my = rand_comp($urandom_range(4, 30));
        p2   = wide_t'(n_px) * n_px + wide_t'(n_py) * n_py + wide_t'(n_pz) * n_pz;
        n_e  = (MB-1)'(pz_scoreboard::isqrt(p2)) + (MB-1)'($urandom_range(0, 1 << 17));
        case (mode)
            6: begin
                n_e  = (MB-1)'({$urandom, $urandom});
                n_px = MB'({$urandom, $urandom});
                n_py = MB'({$urandom, $urandom});
                n_pz = MB'({$urandom, $urandom});
                n_mx = MB'({$urandom, $urandom});
                n_my = MB'({$urandom, $urandom});
            end
            7: n_e = (MB-1)'((n_pz < 0) ? -n_pz : n_pz);          // a = 0
            8: n_e = (MB-1)'($urandom_range(0, 1000));            // unphysical lepton
            9: begin                                              // tiny a, huge pz
                n_e  = (MB-1)'(35'h4_0000_0000 + $urandom_range(0, 255));
                n_pz = MB'(n_e) - MB'($urandom_range(1, 3));
                if ($urandom_range(1)) n_pz = -n_pz;
            end
            default: ;
        endcase
        send_beat();
    endtask

    localparam logic signed [MB-1:0] PMAX = {1'b0, {(MB-1){1'b1}}};
    localparam logic signed [MB-1:0] PMIN = {1'b1, {(MB-1){1'b0}}};
    localparam logic        [MB-2:0] EMAX = '1;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        direct('0, '0, '0, '0, '0, '0);                       // zero energy, zero a
        direct(EMAX, '0, '0, '0, '0, '0);
        direct(EMAX, PMAX, PMAX, PMAX, PMAX, PMAX);
        direct(EMAX, PMIN, PMIN, PMIN, PMIN, PMIN);
        direct(EMAX, PMAX, PMIN, '0, PMIN, PMAX);
        direct('0, 36'sd1000, -36'sd2000, 36'sd500, 36'sd40000, 36'sd3000);
        direct(35'd50000, 36'sd30000, 36'sd0, 36'sd40000, 36'sd90000, -36'sd70000);
        direct(35'd40000, 36'sd0, 36'sd0, -36'sd40000, 36'sd20000, 36'sd0);     // a = 0
        direct(35'd100, 36'sd30000, 36'sd30000, 36'sd30000, 36'sd10, 36'sd10);  // m2 < 0
        direct(35'd60000, 36'sd60000, 36'sd0, 36'sd0, 36'sd900000, 36'sd0);     // real roots
        direct(35'd60000, 36'sd0, 36'sd0, 36'sd1000, 36'sd30000, 36'sd30000);
        direct(35'h4_0000_0001, 36'sd0, 36'sd0, 36'sh4_0000_0000, 36'sd5, 36'sd0);
        direct(35'h4_0000_0001, 36'sd0, 36'sd0, -36'sh4_0000_0000, 36'sd5, 36'sd0);
        direct(EMAX, 36'sd0, 36'sd0, PMAX - 1, PMIN, 36'sd0);
        direct(35'd1, 36'sd0, 36'sd0, 36'sd0, 36'sd0, 36'sd0);
        direct(EMAX, '0, '0, PMIN + 1, '0, '0);                // a = 0 at full scale
        for (int i = 0; i < 430; i++) rand_beat();
        go_idle();

        write_mass('0);
        idle_pct = 72;
        for (int i = 0; i < 440; i++) rand_beat();
        go_idle();

        write_mass('1);
        idle_pct = 0;
        for (int i = 0; i < 440; i++) rand_beat();
        go_idle();

        write_mass(W_MASS_BITS'($urandom));
        idle_pct = 17;
        for (int i = 0; i < 440; i++) rand_beat();
        go_idle();

        write_mass(W_MASS_RESET);
        for (int i = 0; i < 40; i++) rand_beat();
        go_idle();

        $display("%0d events sent over 5 W-mass settings (0, max, random, nominal);",
                 n_items);
        $display("%0d results: %0d with no real root, %0d degenerate, %0d saturated",
                 sb.n_seen, sb.n_noreal, sb.n_degen, sb.n_sat);
        if (sb.n_err == 0 && sb.pending_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d errors, %0d results missing", sb.n_err, sb.pending_q.size());
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
